// File: hdl/quadtree_node_locator_assert.svh
// Assertion macros shared by the quadtree node locator RTL.
// Expects signals named clock and reset in the including scope.
`ifndef QUADTREE_NODE_LOCATOR_ASSERT_SVH
`define QUADTREE_NODE_LOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define QNL_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define QNL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/qnl_pkg.sv
// Package for the quadtree node locator: geometry and width constants.
// No dependencies.
`timescale 1ns / 1ps

package qnl_pkg;

   // Default deepest subdivision the pipeline is built for.
   localparam int QNL_MAX_LEVELS = 8;

   // Root square in Q8.8: x in [-100, 100), y in [-100, 100).
   localparam int ROOT_LEFT  = -25600;
   localparam int ROOT_TOP   = 25600;
   localparam int ROOT_WIDTH = 51200;

   localparam int TAG_W     = 32;
   localparam int COORD_W   = 16;
   localparam int CALC_W    = 18;  // holds +/-25600 plus headroom for edge sums
   localparam int LVL_W     = 4;
   localparam int IDX_OUT_W = 8;

   localparam logic [LVL_W-1:0] DEPTH_RESET = 4'd8;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 56;

endpackage

// File: hdl/quadtree_node_locator.sv
// Quadtree node locator top level: one pipeline stage per tree level.
// Depends on qnl_pkg and quadtree_node_locator_assert.svh.
`timescale 1ns / 1ps
`include "quadtree_node_locator_assert.svh"

// Finds the deepest node of a full quadtree over [-100,100) x [-100,100)
// (Q8.8 coordinates) that holds an axis-aligned box.
//
// Channels:
//   req_*  : one item = entity id plus box edges (min_x, max_x, min_y, max_y).
//   rsp_*  : one item per request, in order: tag, found, level, column, row.
//   csr_*  : write-only tree_depth register (reset value 8, saturated to
//            MAX_LEVELS internally). Write it only while no item is in flight.
//
// Path: an item passes MAX_LEVELS + 1 registers (one for the root test, then one
// per level, the last of which is the output register). Throughput: one item per
// cycle while rsp_tready stays high, set by the per-level stages.
//
// Backpressure: each stage loads whenever it is empty or its successor
// moves, so bubbles collapse and req_tready only drops once every stage
// holds an item and rsp_tready is low. Nothing is dropped or repeated.
//
// Reset (synchronous, active high) empties the pipeline and sets
// tree_depth back to 8.
module quadtree_node_locator
   import qnl_pkg::*;
#(
   parameter int MAX_LEVELS = QNL_MAX_LEVELS  // 1..8 (cell indices leave in 8-bit fields)
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: entity_id[31:0], min_x[47:32], max_x[63:48],
   //            min_y[79:64], max_y[95:80]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: tag_out[31:0], found[32], level[36:33], cell_col[44:37],
   //            cell_row[52:45], zero pad[55:53]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [LVL_W-1:0]      csr_wdata
);

   localparam int N  = MAX_LEVELS;
   localparam int IW = MAX_LEVELS;   // node index width at the deepest level

   // config
   logic [LVL_W-1:0] depth_ff;
   logic [LVL_W-1:0] depth_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_RESET;
      end else if (csr_we) begin
         depth_ff <= csr_wdata;
      end
   end

   assign depth_eff = (depth_ff > LVL_W'(N)) ? LVL_W'(N) : depth_ff;

   // pipeline state, stage 0 = root test, stage k = level k
   logic                       vld_ff [0:N];
   logic                       rdy    [0:N];
   logic [TAG_W-1:0]           tag_ff [0:N];
   logic signed [COORD_W-1:0]  x0_ff  [0:N];
   logic signed [COORD_W-1:0]  x1_ff  [0:N];
   logic signed [COORD_W-1:0]  y0_ff  [0:N];
   logic signed [COORD_W-1:0]  y1_ff  [0:N];
   logic signed [CALC_W-1:0]   cx_ff  [0:N];
   logic signed [CALC_W-1:0]   cy_ff  [0:N];
   logic [IW-1:0]              col_ff [0:N];
   logic [IW-1:0]              row_ff [0:N];
   logic [LVL_W-1:0]           lvl_ff [0:N];
   logic                       fnd_ff [0:N];
   logic                       act_ff [0:N];  // still descending

   logic                       vld_in [0:N];
   logic [TAG_W-1:0]           tag_in [0:N];
   logic signed [COORD_W-1:0]  x0_in  [0:N];
   logic signed [COORD_W-1:0]  x1_in  [0:N];
   logic signed [COORD_W-1:0]  y0_in  [0:N];
   logic signed [COORD_W-1:0]  y1_in  [0:N];
   logic signed [CALC_W-1:0]   cx_in  [0:N];
   logic signed [CALC_W-1:0]   cy_in  [0:N];
   logic [IW-1:0]              col_in [0:N];
   logic [IW-1:0]              row_in [0:N];
   logic [LVL_W-1:0]           lvl_in [0:N];
   logic                       fnd_in [0:N];
   logic                       act_in [0:N];

   logic [N:0]                 vld_all;

   // output views used by the checks
   logic                       rsp_fnd;
   logic [19:0]                rsp_node;  // level, column, row

   for (genvar k = 0; k <= N; k++) begin : g_stage

      // ready chain: load when empty or when the next stage takes our item
      if (k == N) begin : g_rdy_last
         assign rdy[k] = !vld_ff[k] || rsp_tready;
      end else begin : g_rdy_mid
         assign rdy[k] = !vld_ff[k] || rdy[k+1];
      end

      assign vld_all[k] = vld_ff[k];

      if (k == 0) begin : g_root
         logic signed [CALC_W-1:0] x0e, x1e, y0e, y1e;
         logic                     hit;

         always_comb begin
            x0e = CALC_W'(x0_in[0]);
            x1e = CALC_W'(x1_in[0]);
            y0e = CALC_W'(y0_in[0]);
            y1e = CALC_W'(y1_in[0]);
            hit = (x0e >= CALC_W'(ROOT_LEFT))
               && (x1e <  CALC_W'(ROOT_LEFT + ROOT_WIDTH))
               && (y0e >= CALC_W'(ROOT_TOP - ROOT_WIDTH))
               && (y1e <  CALC_W'(ROOT_TOP));
         end

         assign vld_in[0] = req_tvalid;
         assign tag_in[0] = req_tdata[31:0];
         assign x0_in[0]  = req_tdata[47:32];
         assign x1_in[0]  = req_tdata[63:48];
         assign y0_in[0]  = req_tdata[79:64];
         assign y1_in[0]  = req_tdata[95:80];
         assign cx_in[0]  = CALC_W'(ROOT_LEFT);
         assign cy_in[0]  = CALC_W'(ROOT_TOP);
         assign col_in[0] = '0;
         assign row_in[0] = '0;
         assign lvl_in[0] = '0;
         assign fnd_in[0] = hit;
         assign act_in[0] = hit;
      end else begin : g_level
         // width of the children at this level (half the parent's), and full child pair width
         localparam logic signed [CALC_W-1:0] HW  = CALC_W'(ROOT_WIDTH >> k);
         localparam logic signed [CALC_W-1:0] HW2 = CALC_W'(ROOT_WIDTH >> (k - 1));

         logic signed [CALC_W-1:0] x0e, x1e, y0e, y1e;
         logic                     l_ok, r_ok, t_ok, b_ok;
         logic                     hit, go, dx, dy;

         always_comb begin
            x0e  = CALC_W'(x0_ff[k-1]);
            x1e  = CALC_W'(x1_ff[k-1]);
            y0e  = CALC_W'(y0_ff[k-1]);
            y1e  = CALC_W'(y1_ff[k-1]);
            l_ok = (x0e >= cx_ff[k-1])      && (x1e < cx_ff[k-1] + HW);
            r_ok = (x0e >= cx_ff[k-1] + HW) && (x1e < cx_ff[k-1] + HW2);
            t_ok = (y1e <  cy_ff[k-1])      && (y0e >= cy_ff[k-1] - HW);
            b_ok = (y1e <  cy_ff[k-1] - HW) && (y0e >= cy_ff[k-1] - HW2);
            hit  = (l_ok || r_ok) && (t_ok || b_ok);
            go   = act_ff[k-1] && (LVL_W'(k) <= depth_eff);

            // child order: top-left, top-right, bottom-left, bottom-right
            if (l_ok && t_ok) begin
               dx = 1'b0;
               dy = 1'b0;
            end else if (r_ok && t_ok) begin
               dx = 1'b1;
               dy = 1'b0;
            end else if (l_ok && b_ok) begin
               dx = 1'b0;
               dy = 1'b1;
            end else begin
               dx = 1'b1;
               dy = 1'b1;
            end

            vld_in[k] = vld_ff[k-1];
            tag_in[k] = tag_ff[k-1];
            x0_in[k]  = x0_ff[k-1];
            x1_in[k]  = x1_ff[k-1];
            y0_in[k]  = y0_ff[k-1];
            y1_in[k]  = y1_ff[k-1];
            fnd_in[k] = fnd_ff[k-1];
            cx_in[k]  = cx_ff[k-1];
            cy_in[k]  = cy_ff[k-1];
            col_in[k] = col_ff[k-1];
            row_in[k] = row_ff[k-1];
            lvl_in[k] = lvl_ff[k-1];
            act_in[k] = 1'b0;
            if (go && hit) begin
               cx_in[k]  = dx ? cx_ff[k-1] + HW : cx_ff[k-1];
               cy_in[k]  = dy ? cy_ff[k-1] - HW : cy_ff[k-1];
               col_in[k] = IW'({col_ff[k-1], dx});
               row_in[k] = IW'({row_ff[k-1], dy});
               lvl_in[k] = lvl_ff[k-1] + LVL_W'(1);
               act_in[k] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            vld_ff[k] <= vld_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            tag_ff[k] <= tag_in[k];
            x0_ff[k]  <= x0_in[k];
            x1_ff[k]  <= x1_in[k];
            y0_ff[k]  <= y0_in[k];
            y1_ff[k]  <= y1_in[k];
            cx_ff[k]  <= cx_in[k];
            cy_ff[k]  <= cy_in[k];
            col_ff[k] <= col_in[k];
            row_ff[k] <= row_in[k];
            lvl_ff[k] <= lvl_in[k];
            fnd_ff[k] <= fnd_in[k];
            act_ff[k] <= act_in[k];
         end
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = vld_ff[N];
   assign rsp_tdata  = {3'b000,
                        IDX_OUT_W'(row_ff[N]),
                        IDX_OUT_W'(col_ff[N]),
                        lvl_ff[N],
                        fnd_ff[N],
                        tag_ff[N]};

   assign rsp_fnd  = rsp_tdata[32];
   assign rsp_node = rsp_tdata[52:33];

   // assertions
   `QNL_ASSERT_HOLDS(a_miss_is_root, rsp_tvalid && !rsp_fnd, rsp_node == '0, "miss with node set")
   `QNL_ASSERT_HOLDS(a_level_max, rsp_tvalid, lvl_ff[N] <= LVL_W'(N), "level too deep")
   `QNL_ASSERT_HOLDS(a_stall_full, !req_tready, &vld_all, "stall with a bubble")
   `QNL_ASSERT_NEXT(a_advance, vld_ff[N-1] && rdy[N], vld_ff[N], "item lost at the output")

endmodule

// File: verif/quadtree_node_locator_test.sv
// Self-checking bench for quadtree_node_locator: streams boxes, predicts the node found
// at each tree depth setting and checks every response field but the zero pad. Needs qnl_pkg and the RTL.
`timescale 1ns / 1ps

module quadtree_node_locator_test;

   // Bench-side geometry, Q8.8: root square [-100,100) x [-100,100), y grows upward.
   localparam int TREE_LEFT    = -25600;
   localparam int TREE_TOP     = 25600;
   localparam int TREE_WIDTH   = 51200;
   localparam int DEPTH_CAP    = qnl_pkg::QNL_MAX_LEVELS;
   localparam int DRAIN_CYCLES = DEPTH_CAP + 6;   // pipeline depth plus margin
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 140;

   // Request item, first field in the low bits.
   typedef struct packed {
      logic [15:0] max_y;
      logic [15:0] min_y;
      logic [15:0] max_x;
      logic [15:0] min_x;
      logic [31:0] entity_id;
   } box_req_type;

   // Response item, first field in the low bits, zero pad on top.
   typedef struct packed {
      logic [2:0]  pad;
      logic [7:0]  cell_row;
      logic [7:0]  cell_col;
      logic [3:0]  level;
      logic        found;
      logic [31:0] tag_out;
   } node_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [qnl_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [qnl_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                          csr_we = 1'b0;
   logic [qnl_pkg::LVL_W-1:0]     csr_wdata = '0;

   // Boxes waiting to be sent, and node answers predicted for accepted boxes.
   box_req_type  box_backlog[$];
   node_rsp_type node_answers[$];

   logic [3:0] depth_shadow = 4'd8;   // bench copy of tree_depth (reset value)
   int send_idle_pct  = 0;            // chance per cycle the sender holds off
   int recv_stall_pct = 0;            // chance per cycle the receiver stalls
   int error_count    = 0;
   int cycle_count    = 0;
   int boxes_checked  = 0;
   int outside_count  = 0;
   int deepest_count  = 0;

   always #5 clock = ~clock;

   quadtree_node_locator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Half-open containment: left/bottom edges inclusive, right/top exclusive.
   function automatic bit box_inside(int cx, int cy, int w,
                                     int x0, int x1, int y0, int y1);
      return (x0 >= cx) && (x1 < cx + w) && (y0 >= cy - w) && (y1 < cy);
   endfunction

   // Walk down from the root; children tried TL, TR, BL, BR, first hit wins.
   function automatic node_rsp_type locate_node(box_req_type b, logic [3:0] depth_reg);
      node_rsp_type r;
      int x0, x1, y0, y1;
      int lim, cx, cy, w, hw, ncx, ncy, lvl, col, row, k;
      bit hit;
      x0  = int'($signed(b.min_x));
      x1  = int'($signed(b.max_x));
      y0  = int'($signed(b.min_y));
      y1  = int'($signed(b.max_y));
      lim = (int'(depth_reg) > DEPTH_CAP) ? DEPTH_CAP : int'(depth_reg);
      cx  = TREE_LEFT;
      cy  = TREE_TOP;
      w   = TREE_WIDTH;
      lvl = 0;
      col = 0;
      row = 0;
      r   = '0;
      r.tag_out = b.entity_id;
      if (box_inside(cx, cy, w, x0, x1, y0, y1)) begin
         r.found = 1'b1;
         hit = 1'b1;
         while (hit && lvl < lim) begin
            hw  = w / 2;
            hit = 1'b0;
            for (k = 0; k < 4 && !hit; k++) begin
               ncx = cx + (k % 2) * hw;
               ncy = cy - (k / 2) * hw;
               if (box_inside(ncx, ncy, hw, x0, x1, y0, y1)) begin
                  hit = 1'b1;
                  cx  = ncx;
                  cy  = ncy;
                  w   = hw;
                  col = col * 2 + k % 2;
                  row = row * 2 + k / 2;
                  lvl++;
               end
            end
         end
      end
      r.level    = lvl[3:0];
      r.cell_col = col[7:0];
      r.cell_row = row[7:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: holds an item until accepted, predicts at the accepting edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            node_answers.push_back(locate_node(req_tdata, depth_shadow));
         // Free to move on when idle or when the current item just went in.
         if (!req_tvalid || req_tready) begin
            if (box_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tdata  <= box_backlog.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random backpressure, compares each response with the oldest
   // prediction, field by field.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      node_rsp_type got;
      node_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (node_answers.size() == 0) begin
               $error("unexpected response: tag_out %0h with nothing outstanding",
                      got.tag_out);
               error_count++;
            end else begin
               want = node_answers.pop_front();
               boxes_checked++;
               if (!want.found)
                  outside_count++;
               if (want.level == 4'(DEPTH_CAP))
                  deepest_count++;
               if (got.tag_out !== want.tag_out) begin
                  $error("tag_out: expected %0h, actual %0h", want.tag_out, got.tag_out);
                  error_count++;
               end
               if (got.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, got.found);
                  error_count++;
               end
               if (got.level !== want.level) begin
                  $error("level: expected %0d, actual %0d", want.level, got.level);
                  error_count++;
               end
               if (got.cell_col !== want.cell_col) begin
                  $error("cell_col: expected %0d, actual %0d", want.cell_col, got.cell_col);
                  error_count++;
               end
               if (got.cell_row !== want.cell_row) begin
                  $error("cell_row: expected %0d, actual %0d", want.cell_row, got.cell_row);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: a hung pipeline or a lost response ends here.
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   task automatic push_box(logic [31:0] id, int x0, int x1, int y0, int y1);
      box_req_type b;
      b.entity_id = id;
      b.min_x     = x0[15:0];
      b.max_x     = x1[15:0];
      b.min_y     = y0[15:0];
      b.max_y     = y1[15:0];
      box_backlog.push_back(b);
   endtask

   // Wait until nothing is queued, held on the bus or outstanding.
   task automatic wait_drained();
      while (box_backlog.size() != 0 || req_tvalid || node_answers.size() != 0)
         @(negedge clock);
   endtask

   // tree_depth is only touched with the pipeline empty and settled.
   task automatic write_depth(logic [3:0] value);
      @(posedge clock);
      csr_we       <= 1'b1;
      csr_wdata    <= value;
      depth_shadow  = value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly boxes aimed inside a random cell at a random level so the walk
   // goes deep; edges snapped onto cell borders now and then, a few
   // inverted boxes, and a share of raw random words.
   function automatic box_req_type random_box();
      box_req_type b;
      int lvl, w, col, row, left, bottom, x0, x1, y0, y1, t;
      lvl    = $urandom_range(0, DEPTH_CAP);
      w      = TREE_WIDTH >> lvl;
      col    = $urandom_range(0, (1 << lvl) - 1);
      row    = $urandom_range(0, (1 << lvl) - 1);
      left   = TREE_LEFT + col * w;
      bottom = TREE_TOP - (row + 1) * w;
      b.entity_id = $urandom;
      if ($urandom_range(99) < 15) begin
         b.min_x = 16'($urandom);
         b.max_x = 16'($urandom);
         b.min_y = 16'($urandom);
         b.max_y = 16'($urandom);
      end else begin
         x0 = left + $urandom_range(0, w - 1);
         y0 = bottom + $urandom_range(0, w - 1);
         x1 = x0 + ($urandom & ((1 << $urandom_range(0, 15)) - 1));
         y1 = y0 + ($urandom & ((1 << $urandom_range(0, 15)) - 1));
         case ($urandom_range(0, 9))
            0: x0 = left;
            1: x1 = left + w - 1;
            2: x1 = left + w;        // one past the cell's right edge
            3: y0 = bottom;
            4: y1 = bottom + w - 1;
            5: y1 = bottom + w;      // one past the cell's top edge
            default: ;
         endcase
         if (x1 > 32767) x1 = 32767;
         if (y1 > 32767) y1 = 32767;
         if ($urandom_range(0, 19) == 0) begin
            t = x0; x0 = x1; x1 = t;
         end
         if ($urandom_range(0, 19) == 0) begin
            t = y0; y0 = y1; y1 = t;
         end
         b.min_x = x0[15:0];
         b.max_x = x1[15:0];
         b.min_y = y0[15:0];
         b.max_y = y1[15:0];
      end
      return b;
   endfunction

   // Random phase; the sender stops halfway until every answer is back.
   task automatic run_random(int count, int send_pct, int recv_pct);
      int i;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (i = 0; i < count / 2; i++)
         box_backlog.push_back(random_box());
      wait_drained();
      for (i = count / 2; i < count; i++)
         box_backlog.push_back(random_box());
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : sequencer
      int mid_depth;
      int last_depth;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed boxes at the reset depth, no idling.
      push_box(32'h0000_0000, -25600, 25599, -25600, 25599);   // whole root
      push_box(32'h0000_0001, -25600, 25600, -25600, 25599);   // right edge one over
      push_box(32'h0000_0002, -25601, 25599, -25600, 25599);   // left edge one under
      push_box(32'h0000_0003, -25600, 25599, -25600, 25600);   // top edge one over
      push_box(32'h0000_0004, -25600, 25599, -25601, 25599);   // bottom edge one under
      push_box(32'h0000_0005, -32768, -32768, -32768, -32768); // most negative
      push_box(32'h0000_0006, 32767, 32767, 32767, 32767);     // most positive
      push_box(32'h0000_0007, -32768, 32767, -32768, 32767);   // widest box
      push_box(32'h0000_0008, -25600, -25600, 25599, 25599);   // top-left corner point
      push_box(32'hFFFF_FFFF, 25599, 25599, -25600, -25600);   // bottom-right corner point
      push_box(32'hA5A5_A5A5, 0, 0, 0, 0);                     // center point
      push_box(32'h5A5A_5A5A, -1, -1, -1, -1);                 // just below-left of center
      push_box(32'h0000_000C, -1, 0, 10, 20);                  // straddles x = 0
      push_box(32'h0000_000D, 10, 20, -1, 0);                  // straddles y = 0
      push_box(32'h0000_000E, 100, -100, 100, -100);           // inverted, small
      push_box(32'h0000_000F, 25599, -25600, 25599, -25600);   // inverted, held by all
      push_box(32'h0000_0010, -25600, -25401, 25400, 25599);   // exactly one leaf cell
      push_box(32'h0000_0011, -25600, -25400, 25400, 25599);   // leaf cell plus one
      push_box(32'h0000_0012, 0, 25599, 0, 25599);             // exactly top-right quadrant
      push_box(32'h0000_0013, -25600, 0, -25600, -1);          // bottom-left plus one
      push_box(32'h7FFF_FFFF, 25400, 25599, -25600, -25401);   // bottom-right leaf cell
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      // Depth above the cap saturates; then the root-only case.
      write_depth(4'd15);
      run_random(PHASE_ITEMS, 0, 0);
      write_depth(4'd0);
      run_random(PHASE_ITEMS, 88, 0);
      mid_depth = $urandom_range(1, DEPTH_CAP - 1);
      write_depth(mid_depth[3:0]);
      run_random(PHASE_ITEMS, 0, 88);
      write_depth(4'(DEPTH_CAP));
      run_random(PHASE_ITEMS, 10, 10);
      last_depth = $urandom_range(0, 15);
      write_depth(last_depth[3:0]);
      run_random(PHASE_ITEMS, 0, 0);

      $display("covered %0d boxes over tree depths 8, 15, 0, %0d, %0d and %0d", boxes_checked,
               mid_depth, DEPTH_CAP, last_depth);
      $display("%0d boxes fell outside the root, %0d reached the leaf level",
               outside_count, deepest_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
